// ===== rtl/u8dec_pkg.sv =====
// Shared types and codes for the UTF-8 decoder.
`default_nettype none
package u8dec_pkg;

   localparam int CpWidth     = 21;
   localparam int LenWidth    = 3;
   localparam int StatusWidth = 2;
   localparam int QueueDepth  = 4;
   localparam int QueuePtrW   = $clog2(QueueDepth);

   localparam logic [StatusWidth-1:0] STATUS_OK           = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_MISSING_CONT = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_INVALID_LEAD = 2'd2;

   typedef enum logic [2:0] {
      CLS_ASCII,
      CLS_CONT,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_INVALID
   } byte_class_type;

   typedef struct packed {
      byte_class_type cls;
      logic [7:0]     data;
   } q_entry_type;

   // Queue handshake between front and back.
   typedef struct packed {
      logic push;
      logic pop;
   } q_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage
`default_nettype wire

// ===== rtl/u8dec_front.sv =====
// Front end: accepts bytes and classifies each by its leading one bits.
`default_nettype none
module u8dec_front (
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_data_byte,
   input  wire u8dec_pkg::q_status_type q_status,
   output logic                       q_push,
   output u8dec_pkg::q_entry_type     q_entry
);
   import u8dec_pkg::*;

   byte_class_type cls;

   always_comb begin
      if (req_data_byte inside {[8'h00:8'h7F]}) begin
         cls = CLS_ASCII;
      end else if (req_data_byte inside {[8'h80:8'hBF]}) begin
         cls = CLS_CONT;
      end else if (req_data_byte inside {[8'hC0:8'hDF]}) begin
         cls = CLS_LEAD2;
      end else if (req_data_byte inside {[8'hE0:8'hEF]}) begin
         cls = CLS_LEAD3;
      end else if (req_data_byte inside {[8'hF0:8'hF7]}) begin
         cls = CLS_LEAD4;
      end else begin
         cls = CLS_INVALID;
      end
   end

   assign req_stall     = q_status.full;
   assign q_push        = req_valid && !q_status.full;
   assign q_entry.cls   = cls;
   assign q_entry.data  = req_data_byte;

endmodule
`default_nettype wire

// ===== rtl/u8dec_queue.sv =====
// Short queue of classified bytes between front and back.
`default_nettype none
module u8dec_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire u8dec_pkg::q_ctrl_type  ctrl,
   input  wire u8dec_pkg::q_entry_type wr_entry,
   output u8dec_pkg::q_entry_type      rd_entry,
   output u8dec_pkg::q_status_type     status
);
   import u8dec_pkg::*;

   q_entry_type              entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]       count_ff, count_in;
   logic                     do_push, do_pop;

   assign status.full  = (count_ff == (QueuePtrW+1)'(QueueDepth));
   assign status.empty = (count_ff == '0);
   assign do_push      = ctrl.push && !status.full;
   assign do_pop       = ctrl.pop && !status.empty;
   assign rd_entry     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/u8dec_back.sv =====
// Back end: sequence state, code point assembly and the result register.
`default_nettype none
module u8dec_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire u8dec_pkg::q_entry_type              q_entry,
   input  wire u8dec_pkg::q_status_type             q_status,
   output logic                                     q_pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [u8dec_pkg::CpWidth-1:0]            rsp_code_point,
   output logic [u8dec_pkg::LenWidth-1:0]           rsp_byte_length,
   output logic [u8dec_pkg::StatusWidth-1:0]        rsp_status,
   output logic                                     rsp_last
);
   import u8dec_pkg::*;

   logic [1:0]             remain_ff, remain_in;
   logic [LenWidth-1:0]    seq_len_ff, seq_len_in;
   logic [CpWidth-1:0]     partial_ff, partial_in;

   logic                   valid_ff, valid_in;
   logic [CpWidth-1:0]     cp_ff, cp_in;
   logic [LenWidth-1:0]    len_ff, len_in;
   logic [StatusWidth-1:0] status_ff, status_in;
   logic                   last_ff, last_in;

   logic                   can_load;
   logic                   work;
   logic [CpWidth-1:0]     shifted;

   assign can_load = !valid_ff || !rsp_stall;
   assign work     = can_load && !q_status.empty;
   assign shifted  = {partial_ff[CpWidth-7:0], q_entry.data[5:0]};

   always_comb begin
      remain_in  = remain_ff;
      seq_len_in = seq_len_ff;
      partial_in = partial_ff;
      valid_in   = can_load ? 1'b0 : valid_ff;
      cp_in      = cp_ff;
      len_in     = len_ff;
      status_in  = status_ff;
      last_in    = last_ff;
      q_pop      = 1'b0;

      if (work) begin
         if (remain_ff != 2'd0 && q_entry.cls == CLS_CONT) begin
            q_pop     = 1'b1;
            remain_in = remain_ff - 2'd1;
            if (remain_ff == 2'd1) begin
               valid_in   = 1'b1;
               cp_in      = shifted;
               len_in     = seq_len_ff;
               status_in  = STATUS_OK;
               last_in    = 1'b1;
               seq_len_in = '0;
               partial_in = '0;
            end else begin
               partial_in = shifted;
            end
         end else begin
            // Otherwise: flag a broken sequence if one is open, then the byte is treated as a lead.
            if (remain_ff != 2'd0) begin
               valid_in   = 1'b1;
               cp_in      = '0;
               len_in     = '0;
               status_in  = STATUS_MISSING_CONT;
               remain_in  = 2'd0;
               seq_len_in = '0;
               partial_in = '0;
            end
            case (q_entry.cls)
               CLS_LEAD2: begin
                  q_pop      = 1'b1;
                  last_in    = 1'b1;
                  remain_in  = 2'd1;
                  seq_len_in = LenWidth'(2);
                  partial_in = CpWidth'(q_entry.data[4:0]);
               end
               CLS_LEAD3: begin
                  q_pop      = 1'b1;
                  last_in    = 1'b1;
                  remain_in  = 2'd2;
                  seq_len_in = LenWidth'(3);
                  partial_in = CpWidth'(q_entry.data[3:0]);
               end
               CLS_LEAD4: begin
                  q_pop      = 1'b1;
                  last_in    = 1'b1;
                  remain_in  = 2'd3;
                  seq_len_in = LenWidth'(4);
                  partial_in = CpWidth'(q_entry.data[2:0]);
               end
               default: begin
                  if (remain_ff != 2'd0) begin
                     // Second result follows from the same entry, which stays in the queue.
                     last_in = 1'b0;
                  end else begin
                     q_pop    = 1'b1;
                     valid_in = 1'b1;
                     last_in  = 1'b1;
                     if (q_entry.cls == CLS_ASCII) begin
                        cp_in     = CpWidth'(q_entry.data);
                        len_in    = LenWidth'(1);
                        status_in = STATUS_OK;
                     end else begin
                        cp_in     = '0;
                        len_in    = '0;
                        status_in = STATUS_INVALID_LEAD;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff  <= '0;
         seq_len_ff <= '0;
         partial_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         remain_ff  <= remain_in;
         seq_len_ff <= seq_len_in;
         partial_ff <= partial_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff     <= cp_in;
      len_ff    <= len_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_code_point  = cp_ff;
   assign rsp_byte_length = len_ff;
   assign rsp_status      = status_ff;
   assign rsp_last        = last_ff;

endmodule
`default_nettype wire

// ===== rtl/utf8_to_code_point_decoder_unit.sv =====
// Top level of the UTF-8 byte stream to code point decoder.
//
// Request channel: one raw byte per request on req_data_byte, taken at a
// clock edge with req_valid high and req_stall low.
// Response channel: rsp_code_point, rsp_byte_length, rsp_status, rsp_last,
// held in an output register while rsp_valid is high and rsp_stall is high.
// A byte yields zero, one or two responses; rsp_last marks the final one.
// Throughput: one byte per cycle while rsp_stall is low; a byte that breaks a
// sequence and then yields its own response passes through the back end once
// per response. A taken byte is first written into the classify queue; the
// assembly stage then loads its response into the output register.
// A four-entry queue sits between classification and assembly, so requests
// keep being taken while a response waits; req_stall rises only when the
// queue is full, which a stalled response channel eventually causes.
// Reset (synchronous, active high) empties the queue, drops any partial
// sequence and clears rsp_valid.
`default_nettype none
module utf8_to_code_point_decoder_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [7:0]                          req_data_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [u8dec_pkg::CpWidth-1:0]            rsp_code_point,
   output logic [u8dec_pkg::LenWidth-1:0]           rsp_byte_length,
   output logic [u8dec_pkg::StatusWidth-1:0]        rsp_status,
   output logic                                     rsp_last
);
   import u8dec_pkg::*;

   q_entry_type  wr_entry, rd_entry;
   q_ctrl_type   q_ctrl;
   q_status_type q_status;
   logic         push, pop;

   assign q_ctrl.push = push;
   assign q_ctrl.pop  = pop;

   u8dec_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .q_status      (q_status),
      .q_push        (push),
      .q_entry       (wr_entry)
   );

   u8dec_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (q_ctrl),
      .wr_entry (wr_entry),
      .rd_entry (rd_entry),
      .status   (q_status)
   );

   u8dec_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_entry         (rd_entry),
      .q_status        (q_status),
      .q_pop           (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_byte_length (rsp_byte_length),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire

// ===== rtl/u8dec_checker.sv =====
// Port-level checks for the UTF-8 decoder, bound to the top level.
`default_nettype none
module u8dec_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [u8dec_pkg::CpWidth-1:0]       rsp_code_point,
   input wire logic [u8dec_pkg::LenWidth-1:0]      rsp_byte_length,
   input wire logic [u8dec_pkg::StatusWidth-1:0]   rsp_status,
   input wire logic                                rsp_last
);
   import u8dec_pkg::*;

   // Stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_point)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled response changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_code_point == '0
         && rsp_byte_length == '0)
      else $error("error response carries data");

   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_last
         && rsp_byte_length != '0 && rsp_byte_length <= LenWidth'(4))
      else $error("bad length on ok response");

   // Only a missing-continuation response can be followed by another from the same byte.
   a_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == STATUS_MISSING_CONT)
      else $error("non-final response with wrong status");

endmodule

bind utf8_to_code_point_decoder_unit u8dec_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_code_point  (rsp_code_point),
   .rsp_byte_length (rsp_byte_length),
   .rsp_status      (rsp_status),
   .rsp_last        (rsp_last)
);
`default_nettype wire

// ===== tb/utf8_decode_checker.sv =====
`timescale 1ns / 100ps
// Response checker for the UTF-8 decoder: decodes the accepted byte stream and compares.
module utf8_decode_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_stall,
   input  wire logic [7:0]                         req_data_byte,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   input  wire logic [u8dec_pkg::CpWidth-1:0]      rsp_code_point,
   input  wire logic [u8dec_pkg::LenWidth-1:0]     rsp_byte_length,
   input  wire logic [u8dec_pkg::StatusWidth-1:0]  rsp_status,
   input  wire logic                               rsp_last,
   output int                                      failures,
   output int                                      pending,
   output int                                      responses_checked
);
   import u8dec_pkg::*;

   localparam logic [7:0] ContMask = 8'hC0;
   localparam logic [7:0] ContTag  = 8'h80;

   typedef struct packed {
      logic [CpWidth-1:0]     code_point;
      logic [LenWidth-1:0]    byte_length;
      logic [StatusWidth-1:0] status;
      logic                   last;
   } decoded_result_type;

   logic [1:0]          cont_left;
   logic [LenWidth-1:0] seq_len;
   logic [CpWidth-1:0]  partial_cp;
   decoded_result_type  expected_results [$];
   decoded_result_type  oldest;

   function automatic int count_leading_ones(input logic [7:0] b);
      int n;
      n = 0;
      while (n < 8 && b[7-n]) n++;
      return n;
   endfunction

   // Advances the decoder state by one byte and queues the responses it causes.
   task automatic decode_byte(input logic [7:0] b);
      decoded_result_type found [2];
      int                 n_found;
      int                 ones;
      n_found = 0;
      if (cont_left != 0 && (b & ContMask) == ContTag) begin
         partial_cp = {partial_cp[CpWidth-7:0], b[5:0]};
         cont_left  = cont_left - 2'd1;
         if (cont_left == 0) begin
            found[n_found] = '{partial_cp, seq_len, STATUS_OK, 1'b0};
            n_found++;
            seq_len    = '0;
            partial_cp = '0;
         end
      end else begin
         if (cont_left != 0) begin
            // sequence broken: report it, drop it, then retry the byte as a lead
            found[n_found] = '{'0, '0, STATUS_MISSING_CONT, 1'b0};
            n_found++;
            cont_left  = '0;
            seq_len    = '0;
            partial_cp = '0;
         end
         ones = count_leading_ones(b);
         if (ones == 0) begin
            found[n_found] = '{CpWidth'(b), LenWidth'(1), STATUS_OK, 1'b0};
            n_found++;
         end else if (ones >= 2 && ones <= 4) begin
            seq_len    = LenWidth'(ones);
            cont_left  = 2'(ones - 1);
            partial_cp = CpWidth'(b & (8'h7F >> ones));
         end else begin
            found[n_found] = '{'0, '0, STATUS_INVALID_LEAD, 1'b0};
            n_found++;
         end
      end
      for (int i = 0; i < n_found; i++) begin
         found[i].last = (i == n_found - 1);
         expected_results.push_back(found[i]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cont_left         = '0;
         seq_len           = '0;
         partial_cp        = '0;
         failures          = 0;
         responses_checked = 0;
         expected_results.delete();
      end else begin
         if (req_valid && !req_stall) decode_byte(req_data_byte);
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected response: code_point %0h status %0d", rsp_code_point,
                      rsp_status);
               failures++;
            end else begin
               oldest = expected_results.pop_front();
               responses_checked++;
               if (rsp_code_point !== oldest.code_point) begin
                  $error("code_point: expected %0h, got %0h", oldest.code_point,
                         rsp_code_point);
                  failures++;
               end
               if (rsp_byte_length !== oldest.byte_length) begin
                  $error("byte_length: expected %0d, got %0d", oldest.byte_length,
                         rsp_byte_length);
                  failures++;
               end
               if (rsp_status !== oldest.status) begin
                  $error("status: expected %0d, got %0d", oldest.status, rsp_status);
                  failures++;
               end
               if (rsp_last !== oldest.last) begin
                  $error("last: expected %0d, got %0d", oldest.last, rsp_last);
                  failures++;
               end
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the UTF-8 decoder testbench: clock, reset, byte stimulus and verdict.
module testbench;
   import u8dec_pkg::*;

   localparam int ItemCount  = 1350;
   localparam int StallLimit = 2000;
   localparam int TailCycles = 8;

   logic                   clock;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_data_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_stall     = 1'b0;
   logic [CpWidth-1:0]     rsp_code_point;
   logic [LenWidth-1:0]    rsp_byte_length;
   logic [StatusWidth-1:0] rsp_status;
   logic                   rsp_last;

   int failures;
   int pending;
   int responses_checked;
   int bytes_sent   = 0;
   int full_seqs    = 0;
   int broken_seqs  = 0;
   int idle_cycles  = 0;
   bit quiet        = 1'b0;

   // lead/continuation edge cases: code point extremes, stray and invalid leads,
   // and broken sequences followed by ASCII, a new sequence and an invalid lead
   logic [7:0] directed_stream [24] = '{
      8'h00, 8'h7F, 8'h80,
      8'hC0, 8'h80, 8'hDF, 8'hBF,
      8'hEF, 8'hBF, 8'hBF,
      8'hF7, 8'hBF, 8'hBF, 8'hBF,
      8'hF8, 8'hFF,
      8'hC3, 8'h41,
      8'hE2, 8'h82, 8'hC3, 8'hA9,
      8'hE2, 8'hFF
   };

   utf8_to_code_point_decoder_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_byte_length (rsp_byte_length),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   utf8_decode_checker decode_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_point    (rsp_code_point),
      .rsp_byte_length   (rsp_byte_length),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last),
      .failures          (failures),
      .pending           (pending),
      .responses_checked (responses_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 14);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
         $display("Watchdog: no request or response moved for %0d cycles", StallLimit);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] value);
      while (!quiet && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      // stretch with no gaps on either side
      quiet = (bytes_sent >= 600 && bytes_sent < 900);
   endtask

   // lead of the given length followed by cont_count random continuation bytes
   task automatic send_sequence(input int len, input int cont_count);
      logic [7:0] lead;
      case (len)
         2:       lead = {3'b110, 5'($urandom)};
         3:       lead = {4'b1110, 4'($urandom)};
         default: lead = {5'b11110, 3'($urandom)};
      endcase
      send_byte(lead);
      repeat (cont_count) send_byte({2'b10, 6'($urandom)});
   endtask

   initial begin
      int pick;
      int len;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_stream[i]) send_byte(directed_stream[i]);

      while (bytes_sent < ItemCount) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            send_byte({1'b0, 7'($urandom)});
         end else if (pick < 75) begin
            len = $urandom_range(2, 4);
            send_sequence(len, len - 1);
            full_seqs++;
         end else if (pick < 85) begin
            len = $urandom_range(2, 4);
            send_sequence(len, $urandom_range(0, len - 2));
            broken_seqs++;
         end else if (pick < 95) begin
            send_byte(8'($urandom));
         end else begin
            send_byte(8'($urandom_range(8'hF8, 8'hFF)));
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);

      $display("Sent %0d bytes: directed edge cases, %0d complete and %0d cut-short sequences,",
               bytes_sent, full_seqs, broken_seqs);
      $display("plus ASCII, stray and invalid bytes; %0d responses compared.",
               responses_checked);
      if (failures == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
